@@ hdl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Included by every file that carries concurrent assertions; expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sspa_pkg.sv @@
// Package for the square slot pool allocator: sizes, codes, types and helpers.
// Used by every module of the block; depends on nothing else.
package sspa_pkg;

    localparam int MAX_TEX_LOG2  = 8;
    localparam int MIN_SLOT      = 4;
    localparam int MAX_POOLS     = 8;

    localparam int MIN_LOG2      = $clog2(MIN_SLOT);
    localparam int POOL_CAP_LOG2 = 2 * (MAX_TEX_LOG2 - MIN_LOG2);
    localparam int SLOT_W        = POOL_CAP_LOG2;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int WPOOL_W       = POOL_CAP_LOG2 - BIT_W;
    localparam int POOL_W        = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int ADDR_W        = POOL_W + WPOOL_W;
    localparam int PCNT_W        = $clog2(MAX_POOLS + 1);
    localparam int D_W           = $clog2(MAX_TEX_LOG2 - MIN_LOG2 + 1);
    localparam int USED_W        = $clog2(MAX_POOLS * (1 << POOL_CAP_LOG2) + 1);
    localparam int TEXL_W        = 4;
    localparam int WK_W          = WPOOL_W + 1;

    localparam logic [TEXL_W-1:0] TEX_RESET  = TEXL_W'(MAX_TEX_LOG2);
    localparam logic [TEXL_W-1:0] TEX_LIMIT  = TEXL_W'(MAX_TEX_LOG2);
    localparam logic [TEXL_W-1:0] SL_MIN     = TEXL_W'(MIN_LOG2);
    localparam logic [PCNT_W-1:0] POOL_LIMIT = PCNT_W'(MAX_POOLS);

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_BAD   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_REQ    = 2'd1,
        ST_NO_POOL    = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PSEARCH,
        S_CLEAR,
        S_TAKE_RD,
        S_TAKE_WR,
        S_SCAN,
        S_FREE_CHK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                bad;
        logic [TEXL_W-1:0]   sl;
        logic [D_W-1:0]      d;
    } t_req_info;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   wdata;
    } t_mem_cmd;

    typedef struct packed {
        logic                found;
        logic [BIT_W-1:0]    pos;
    } t_scan_res;

    // Mask of slot indices below the slot count 4^d.
    function automatic logic [SLOT_W-1:0] slot_mask(input logic [D_W-1:0] d);
        logic [SLOT_W:0] one;
        one = (SLOT_W + 1)'(1) << {d, 1'b0};
        return SLOT_W'(one - (SLOT_W + 1)'(1));
    endfunction

    // Bits of a bitmap word that belong to real slots (all of them once a pool fills a word).
    function automatic logic [WORD_W-1:0] word_valid(input logic [SLOT_W-1:0] nmask);
        logic [WORD_W:0] t;
        t = (WORD_W + 1)'(1) << ((BIT_W + 1)'(nmask[BIT_W-1:0]) + (BIT_W + 1)'(1));
        return WORD_W'(t - (WORD_W + 1)'(1));
    endfunction

endpackage

@@ hdl/sspa_decode.sv @@
// Request checker: validates an alloc tile edge and derives the slot size.
// Depends on sspa_pkg.
module sspa_decode (
    input  logic [11:0]                    i_width,
    input  logic [11:0]                    i_height,
    input  logic [sspa_pkg::TEXL_W-1:0]    i_tex_log2,
    output sspa_pkg::t_req_info            o_info
);
    import sspa_pkg::*;

    logic [12:0]       edge_px;
    logic [TEXL_W-1:0] wl;
    logic [TEXL_W-1:0] sl;
    logic [TEXL_W-1:0] diff;
    logic              shape_bad;

    always_comb begin
        wl = '0;
        for (int i = 0; i < 12; i++) begin
            if (i_width[i]) begin
                wl = TEXL_W'(i);
            end
        end
    end

    always_comb begin
        edge_px   = 13'd1 << i_tex_log2;
        shape_bad = (i_width != i_height) || (i_width == 12'd0) ||
                    ((i_width & (i_width - 12'd1)) != 12'd0) ||
                    ({1'b0, i_width} > edge_px);
        sl        = (wl < SL_MIN) ? SL_MIN : wl;
        diff      = i_tex_log2 - sl;
        o_info.bad = shape_bad || (sl > i_tex_log2);
        o_info.sl  = sl;
        o_info.d   = diff[D_W-1:0];
    end

endmodule

@@ hdl/sspa_bitmap.sv @@
// Used-slot bitmap of all pools, one 32-bit word per access, with the zero-bit scan unit.
// Depends on sspa_pkg.
module sspa_bitmap (
    input  logic                          i_clk,
    input  sspa_pkg::t_mem_cmd            i_cmd,
    input  logic [sspa_pkg::WORD_W-1:0]   i_ignore,
    output logic [sspa_pkg::WORD_W-1:0]   o_rdata,
    output sspa_pkg::t_scan_res           o_scan
);
    import sspa_pkg::*;

    logic [WORD_W-1:0] mem [1 << ADDR_W];
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] busy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_cmd.we) begin
                mem[i_cmd.addr] <= i_cmd.wdata;
            end else begin
                r_rdata <= mem[i_cmd.addr];
            end
        end
    end

    // Lowest clear bit of the word just read, ignoring the masked positions.
    always_comb begin
        busy         = r_rdata | i_ignore;
        o_scan.found = ~&busy;
        o_scan.pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                o_scan.pos = BIT_W'(i);
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/square_slot_pool_allocator.sv @@
// Square slot pool allocator top level: request sequencer, pool tables and output register.
// Depends on sspa_pkg, sspa_decode, sspa_bitmap and assert_macros.svh.
`include "assert_macros.svh"

// One request is taken at a time; the block stalls its input until the result is in the
// output register. A free reads the handle's bitmap word, then clears its bit if set; a free
// with an out-of-range handle, a clear, an unknown action or a malformed alloc goes from
// decode straight to the output stage. An alloc walks the pool table entries (including the
// one past the last open pool when a pool is opened or none is left), wipes each bitmap word
// of a newly opened pool (up to 128), reads and sets the taken slot's word, then rescans one
// 32-bit bitmap word at a time for the next free slot (at most the pool's word count plus
// one, 129 for 4x4 tiles in a 256x256 pool); the single-port bitmap memory serves one word
// per cycle. Writing tex_size_log2 drops every pool; reset and a clear run no clearing pass.
module square_slot_pool_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sspa_pkg::TEXL_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [11:0]                  i_req_width,
    input  logic [11:0]                  i_req_height,
    input  logic [3:0]                   i_free_pool,
    input  logic [11:0]                  i_free_slot,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [2:0]                   o_pool_index,
    output logic [11:0]                  o_slot_index,
    output logic [7:0]                   o_origin_x,
    output logic [7:0]                   o_origin_y,
    output logic [8:0]                   o_tile_size,
    output logic                         o_any_in_use
);
    import sspa_pkg::*;

    // Control registers.
    t_state              r_state, n_state;
    logic [TEXL_W-1:0]   r_tex, n_tex;
    logic [PCNT_W-1:0]   r_pool_count, n_pool_count;
    logic [USED_W-1:0]   r_used_total, n_used_total;
    logic [MAX_POOLS-1:0] r_hv, n_hv;
    logic                r_out_valid, n_out_valid;

    // Working registers.
    t_action             r_act, n_act;
    logic [11:0]         r_w, n_w;
    logic [11:0]         r_h, n_h;
    logic [3:0]          r_fpool, n_fpool;
    logic [11:0]         r_fslot, n_fslot;
    logic [TEXL_W-1:0]   r_sl, n_sl;
    logic [D_W-1:0]      r_d, n_d;
    logic [PCNT_W-1:0]   r_p, n_p;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_start, n_start;
    logic [WK_W-1:0]     r_k, n_k;
    logic                r_chkv, n_chkv;
    logic [WPOOL_W-1:0]  r_cw, n_cw;
    t_status             r_status, n_status;
    logic [TEXL_W-1:0]   r_psize [MAX_POOLS];
    logic [TEXL_W-1:0]   n_psize [MAX_POOLS];
    logic [SLOT_W-1:0]   r_hint  [MAX_POOLS];
    logic [SLOT_W-1:0]   n_hint  [MAX_POOLS];

    // Output register.
    t_status             r_o_status, n_o_status;
    logic [2:0]          r_o_pool, n_o_pool;
    logic [11:0]         r_o_slot, n_o_slot;
    logic [7:0]          r_o_x, n_o_x;
    logic [7:0]          r_o_y, n_o_y;
    logic [8:0]          r_o_size, n_o_size;
    logic                r_o_any, n_o_any;

    logic [TEXL_W-1:0]   tl_eff;
    t_req_info           req;
    t_mem_cmd            mem_cmd;
    logic [WORD_W-1:0]   ignore;
    logic [WORD_W-1:0]   rdata;
    t_scan_res           scan;

    logic [POOL_W-1:0]   fp_idx;
    logic [POOL_W-1:0]   p_idx;
    logic [TEXL_W-1:0]   fdiff;
    logic [D_W-1:0]      fd;
    logic                free_ok;
    logic [SLOT_W-1:0]   nmask;
    logic [WPOOL_W-1:0]  wmask;
    logic [WK_W-1:0]     nwords;
    logic [WK_W-1:0]     chk_idx;
    logic [WPOOL_W-1:0]  issue_w;
    logic [SLOT_W-1:0]   take_slot;
    logic                alloc_ok;
    logic [19:0]         col_full;
    logic [19:0]         row_full;
    logic [WORD_W-1:0]   bitsel;
    logic                tile_out;
    logic                tile_ok;

    assign tl_eff = (r_tex > TEX_LIMIT) ? TEX_LIMIT : r_tex;

    sspa_decode u_decode (
        .i_width    (r_w),
        .i_height   (r_h),
        .i_tex_log2 (tl_eff),
        .o_info     (req)
    );

    sspa_bitmap u_bitmap (
        .i_clk    (i_clk),
        .i_cmd    (mem_cmd),
        .i_ignore (ignore),
        .o_rdata  (rdata),
        .o_scan   (scan)
    );

    always_comb begin
        fp_idx    = r_fpool[POOL_W-1:0];
        p_idx     = r_p[POOL_W-1:0];
        fdiff     = tl_eff - r_psize[fp_idx];
        fd        = fdiff[D_W-1:0];
        free_ok   = ({1'b0, r_fpool} < 5'(r_pool_count)) && (r_psize[fp_idx] <= tl_eff) &&
                    ((r_fslot >> {fd, 1'b0}) == 12'd0);
        nmask     = slot_mask(r_d);
        wmask     = nmask[SLOT_W-1:BIT_W];
        nwords    = {1'b0, wmask} + WK_W'(1);
        chk_idx   = r_k - WK_W'(1);
        issue_w   = (r_start[SLOT_W-1:BIT_W] + r_k[WPOOL_W-1:0]) & wmask;
        take_slot = r_hint[p_idx] & nmask;
        ignore    = ~word_valid(nmask);
        if (chk_idx == '0) begin
            ignore = ignore | ((WORD_W'(1) << r_start[BIT_W-1:0]) - WORD_W'(1));
        end
        bitsel    = WORD_W'(1) << ((r_state == S_FREE_CHK) ? r_fslot[BIT_W-1:0]
                                                           : r_slot[BIT_W-1:0]);
        alloc_ok  = (r_act == ACT_ALLOC) && (r_status == ST_OK);
        col_full  = (20'(r_slot) >> r_d) << r_sl;
        row_full  = 20'(r_slot & ((SLOT_W'(1) << r_d) - SLOT_W'(1))) << r_sl;
    end

    always_comb begin
        n_state      = r_state;
        n_tex        = r_tex;
        n_pool_count = r_pool_count;
        n_used_total = r_used_total;
        n_hv         = r_hv;
        n_out_valid  = r_out_valid;
        n_act        = r_act;
        n_w          = r_w;
        n_h          = r_h;
        n_fpool      = r_fpool;
        n_fslot      = r_fslot;
        n_sl         = r_sl;
        n_d          = r_d;
        n_p          = r_p;
        n_slot       = r_slot;
        n_start      = r_start;
        n_k          = r_k;
        n_chkv       = r_chkv;
        n_cw         = r_cw;
        n_status     = r_status;
        n_psize      = r_psize;
        n_hint       = r_hint;
        n_o_status   = r_o_status;
        n_o_pool     = r_o_pool;
        n_o_slot     = r_o_slot;
        n_o_x        = r_o_x;
        n_o_y        = r_o_y;
        n_o_size     = r_o_size;
        n_o_any      = r_o_any;
        mem_cmd      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = t_action'(i_action);
                    n_w     = i_req_width;
                    n_h     = i_req_height;
                    n_fpool = i_free_pool;
                    n_fslot = i_free_slot;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_state  = S_FINISH;
                case (r_act)
                    ACT_ALLOC: begin
                        n_sl = req.sl;
                        n_d  = req.d;
                        n_p  = '0;
                        if (req.bad) begin
                            n_status = ST_BAD_REQ;
                        end else begin
                            n_state = S_PSEARCH;
                        end
                    end
                    ACT_FREE: begin
                        if (free_ok) begin
                            mem_cmd.en   = 1'b1;
                            mem_cmd.addr = {fp_idx, r_fslot[SLOT_W-1:BIT_W]};
                            n_state      = S_FREE_CHK;
                        end else begin
                            n_status = ST_BAD_HANDLE;
                        end
                    end
                    ACT_CLEAR: begin
                        n_pool_count = '0;
                        n_used_total = '0;
                        n_hv         = '0;
                    end
                    default: begin
                        n_status = ST_BAD_REQ;
                    end
                endcase
            end
            S_PSEARCH: begin
                if (r_p == r_pool_count) begin
                    if (r_pool_count >= POOL_LIMIT) begin
                        n_status = ST_NO_POOL;
                        n_state  = S_FINISH;
                    end else begin
                        // Open a new pool; its bitmap words are wiped before the first take.
                        n_psize[p_idx] = r_sl;
                        n_hint[p_idx]  = '0;
                        n_hv[p_idx]    = 1'b1;
                        n_pool_count   = r_pool_count + PCNT_W'(1);
                        n_k            = '0;
                        n_state        = S_CLEAR;
                    end
                end else if ((r_psize[p_idx] == r_sl) && r_hv[p_idx]) begin
                    n_state = S_TAKE_RD;
                end else begin
                    n_p = r_p + PCNT_W'(1);
                end
            end
            S_CLEAR: begin
                mem_cmd.en   = 1'b1;
                mem_cmd.we   = 1'b1;
                mem_cmd.addr = {p_idx, r_k[WPOOL_W-1:0]};
                n_k          = r_k + WK_W'(1);
                if (r_k[WPOOL_W-1:0] == wmask) begin
                    n_state = S_TAKE_RD;
                end
            end
            S_TAKE_RD: begin
                n_slot       = take_slot;
                mem_cmd.en   = 1'b1;
                mem_cmd.addr = {p_idx, take_slot[SLOT_W-1:BIT_W]};
                n_state      = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                mem_cmd.en    = 1'b1;
                mem_cmd.we    = 1'b1;
                mem_cmd.addr  = {p_idx, r_slot[SLOT_W-1:BIT_W]};
                mem_cmd.wdata = rdata | bitsel;
                n_used_total  = r_used_total + USED_W'(1);
                n_start       = (r_slot + SLOT_W'(1)) & nmask;
                n_k           = '0;
                n_chkv        = 1'b0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                // One word is read per cycle while the word read the cycle before is checked.
                // The start word comes round again last, for the slots below the start.
                mem_cmd.en   = 1'b1;
                mem_cmd.addr = {p_idx, issue_w};
                n_cw         = issue_w;
                n_k          = r_k + WK_W'(1);
                n_chkv       = 1'b1;
                if (r_chkv) begin
                    if (scan.found) begin
                        n_hint[p_idx] = {r_cw, scan.pos};
                        n_hv[p_idx]   = 1'b1;
                        n_state       = S_FINISH;
                    end else if (chk_idx == nwords) begin
                        n_hv[p_idx] = 1'b0;
                        n_state     = S_FINISH;
                    end
                end
            end
            S_FREE_CHK: begin
                n_state = S_FINISH;
                if ((rdata & bitsel) == '0) begin
                    n_status = ST_BAD_HANDLE;
                end else begin
                    mem_cmd.en     = 1'b1;
                    mem_cmd.we     = 1'b1;
                    mem_cmd.addr   = {fp_idx, r_fslot[SLOT_W-1:BIT_W]};
                    mem_cmd.wdata  = rdata & ~bitsel;
                    if (r_used_total != '0) begin
                        n_used_total = r_used_total - USED_W'(1);
                    end
                    n_hint[fp_idx] = r_fslot;
                    n_hv[fp_idx]   = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_any     = (r_used_total != '0);
                    n_o_pool    = alloc_ok ? p_idx : 3'd0;
                    n_o_slot    = alloc_ok ? r_slot : 12'd0;
                    n_o_x       = alloc_ok ? col_full[7:0] : 8'd0;
                    n_o_y       = alloc_ok ? row_full[7:0] : 8'd0;
                    n_o_size    = alloc_ok ? r_w[8:0] : 9'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A texture size write drops every pool.
        if (i_cfg_we) begin
            n_tex        = i_cfg_data;
            n_pool_count = '0;
            n_used_total = '0;
            n_hv         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tex        <= TEX_RESET;
            r_pool_count <= '0;
            r_used_total <= '0;
            r_hv         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tex        <= n_tex;
            r_pool_count <= n_pool_count;
            r_used_total <= n_used_total;
            r_hv         <= n_hv;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_w        <= n_w;
        r_h        <= n_h;
        r_fpool    <= n_fpool;
        r_fslot    <= n_fslot;
        r_sl       <= n_sl;
        r_d        <= n_d;
        r_p        <= n_p;
        r_slot     <= n_slot;
        r_start    <= n_start;
        r_k        <= n_k;
        r_chkv     <= n_chkv;
        r_cw       <= n_cw;
        r_status   <= n_status;
        r_psize    <= n_psize;
        r_hint     <= n_hint;
        r_o_status <= n_o_status;
        r_o_pool   <= n_o_pool;
        r_o_slot   <= n_o_slot;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_size   <= n_o_size;
        r_o_any    <= n_o_any;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_pool_index = r_o_pool;
    assign o_slot_index = r_o_slot;
    assign o_origin_x   = r_o_x;
    assign o_origin_y   = r_o_y;
    assign o_tile_size  = r_o_size;
    assign o_any_in_use = r_o_any;

    assign tile_out = o_out_valid && (o_tile_size != 9'd0);
    assign tile_ok  = o_any_in_use && (o_status == ST_OK);

    `SSPA_ASSERT_IMP(a_pool_bound, 1'b1, r_pool_count <= POOL_LIMIT, "too many pools open")
    `SSPA_ASSERT_IMP(a_empty_unused, r_pool_count == '0, r_used_total == '0, "use with no pool")
    `SSPA_ASSERT_IMP(a_alloc_in_use, tile_out, tile_ok, "allocated tile reported without use")

endmodule
